### design/rgbhsv_pkg.sv
package rgbhsv_pkg;

  parameter int unsigned CHANNEL_BITS_DEF = 12;

  // stages ahead of the divider: compare, difference, numerator, dividend
  parameter int unsigned PRE_STAGES = 4;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  function automatic int unsigned tdata_bits(int unsigned chan_bits);
    return ((3 * chan_bits + 7) / 8) * 8;
  endfunction

endpackage

### design/rgbhsv_div_pipe.sv
module rgbhsv_div_pipe #(
  parameter int unsigned QuotBits = 12,
  parameter int unsigned DivBits  = 12
) (
  input  logic                         clk_i,
  input  logic [QuotBits-1:0]          en_i,
  input  logic [QuotBits+DivBits-1:0]  dividend_i,
  input  logic [DivBits-1:0]           divisor_i,
  output logic [QuotBits-1:0]          quotient_o
);

  logic [DivBits-1:0]  rem_q  [QuotBits];
  logic [QuotBits-1:0] low_q  [QuotBits];
  logic [QuotBits-1:0] quot_q [QuotBits];
  logic [DivBits-1:0]  div_q  [QuotBits];

  for (genvar k = 0; k < QuotBits; k++) begin : g_step
    logic [DivBits-1:0]  prev_rem;
    logic [QuotBits-1:0] prev_low;
    logic [QuotBits-1:0] prev_quot;
    logic [DivBits-1:0]  prev_div;
    logic [DivBits:0]    trial;
    logic [DivBits:0]    diff;
    logic                take;

    if (k == 0) begin : g_first
      assign prev_rem  = dividend_i[QuotBits+DivBits-1:QuotBits];
      assign prev_low  = dividend_i[QuotBits-1:0];
      assign prev_quot = '0;
      assign prev_div  = divisor_i;
    end else begin : g_next
      assign prev_rem  = rem_q[k-1];
      assign prev_low  = low_q[k-1];
      assign prev_quot = quot_q[k-1];
      assign prev_div  = div_q[k-1];
    end

    // one restoring step: shift in a dividend bit, subtract if it fits
    always_comb begin
      trial = {prev_rem, prev_low[QuotBits-1]};
      diff  = trial - {1'b0, prev_div};
      take  = (trial >= {1'b0, prev_div});
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= take ? diff[DivBits-1:0] : trial[DivBits-1:0];
        low_q[k]  <= {prev_low[QuotBits-2:0], 1'b0};
        quot_q[k] <= {prev_quot[QuotBits-2:0], take};
        div_q[k]  <= prev_div;
      end
    end
  end

  assign quotient_o = quot_q[QuotBits-1];

endmodule

### design/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter. Each channel is unsigned fixed point of
// CHANNEL_BITS bits with all ones standing for 1.0; value is the largest
// channel, saturation the spread over value (0 for black), hue the fraction
// of a turn (0 for grey), all quotients truncated. One pixel per clock is
// taken and delivered when the output does not stall; from input to output a
// pixel passes four stages of compare and add, then a restoring divider that
// settles one quotient bit per stage. Stalls on the output back up stage by
// stage, and empty stages are filled while the output waits.
module rgb_to_hsv_converter #(
  parameter int unsigned CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // red_in, green_in, blue_in, zero pad
  input  logic [rgbhsv_pkg::tdata_bits(CHANNEL_BITS)-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // hue_out, saturation_out, value_out, zero pad
  output logic [rgbhsv_pkg::tdata_bits(CHANNEL_BITS)-1:0] m_axis_tdata_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned W      = CHANNEL_BITS;
  localparam int unsigned TW     = tdata_bits(CHANNEL_BITS);
  localparam int unsigned Stages = PRE_STAGES + W;
  localparam int unsigned HW     = W + 3;
  localparam int unsigned NW     = W + 4;

  logic [Stages-1:0] valid_q;
  logic [Stages:0]   ld;

  always_comb begin
    ld[Stages] = m_axis_tready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      ld[k] = !valid_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ld[0]) valid_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < Stages; k++) begin
        if (ld[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage 1: largest, smallest, dominant channel
  logic [W-1:0] red, green, blue;
  logic [W-1:0] vmax_d, vmin_d;
  sector_e      sector_d;

  assign red   = s_axis_tdata_i[W-1:0];
  assign green = s_axis_tdata_i[2*W-1:W];
  assign blue  = s_axis_tdata_i[3*W-1:2*W];

  always_comb begin
    sector_d = SECT_RED;
    vmax_d   = red;
    if (green > vmax_d) begin
      sector_d = SECT_GREEN;
      vmax_d   = green;
    end
    if (blue > vmax_d) begin
      sector_d = SECT_BLUE;
      vmax_d   = blue;
    end
    vmin_d = red;
    if (green < vmin_d) vmin_d = green;
    if (blue < vmin_d) vmin_d = blue;
  end

  logic [W-1:0] r1_q, g1_q, b1_q, vmax1_q, vmin1_q;
  sector_e      sector1_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      r1_q      <= red;
      g1_q      <= green;
      b1_q      <= blue;
      vmax1_q   <= vmax_d;
      vmin1_q   <= vmin_d;
      sector1_q <= sector_d;
    end
  end

  // stage 2: spread and signed channel difference
  logic signed [W:0] diff_d;

  always_comb begin
    case (sector1_q)
      SECT_RED:   diff_d = $signed({1'b0, g1_q}) - $signed({1'b0, b1_q});
      SECT_GREEN: diff_d = $signed({1'b0, b1_q}) - $signed({1'b0, r1_q});
      SECT_BLUE:  diff_d = $signed({1'b0, r1_q}) - $signed({1'b0, g1_q});
      default:    diff_d = '0;
    endcase
  end

  logic [W-1:0]      spread2_q, vmax2_q;
  logic signed [W:0] diff2_q;
  sector_e           sector2_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      spread2_q <= vmax1_q - vmin1_q;
      vmax2_q   <= vmax1_q;
      diff2_q   <= diff_d;
      sector2_q <= sector1_q;
    end
  end

  // stage 3: hue numerator in [0, 6 * spread) and divisors
  logic signed [NW-1:0] sp_ext, diff_ext, six_sp, num_d;

  always_comb begin
    sp_ext   = $signed({{(NW-W){1'b0}}, spread2_q});
    diff_ext = $signed({{(NW-W-1){diff2_q[W]}}, diff2_q});
    six_sp   = (sp_ext <<< 2) + (sp_ext <<< 1);
    case (sector2_q)
      SECT_RED:   num_d = diff_ext[NW-1] ? diff_ext + six_sp : diff_ext;
      SECT_GREEN: num_d = (sp_ext <<< 1) + diff_ext;
      SECT_BLUE:  num_d = (sp_ext <<< 2) + diff_ext;
      default:    num_d = '0;
    endcase
  end

  logic [HW-1:0] num3_q, hdiv3_q;
  logic [W-1:0]  spread3_q, sdiv3_q, vmax3_q;

  // zero divisor goes to one: its dividend is zero then, so the quotient is too
  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      num3_q    <= num_d[HW-1:0];
      hdiv3_q   <= (spread2_q == '0) ? HW'(1) : six_sp[HW-1:0];
      spread3_q <= spread2_q;
      sdiv3_q   <= (vmax2_q == '0) ? W'(1) : vmax2_q;
      vmax3_q   <= vmax2_q;
    end
  end

  // stage 4: dividends scaled by full scale
  logic [W+HW-1:0] hnum4_q;
  logic [2*W-1:0]  snum4_q;
  logic [HW-1:0]   hdiv4_q;
  logic [W-1:0]    sdiv4_q, vmax4_q;

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      hnum4_q <= {num3_q, {W{1'b0}}} - {{W{1'b0}}, num3_q};
      snum4_q <= {spread3_q, {W{1'b0}}} - {{W{1'b0}}, spread3_q};
      hdiv4_q <= hdiv3_q;
      sdiv4_q <= sdiv3_q;
      vmax4_q <= vmax3_q;
    end
  end

  // divider stages
  logic [W-1:0] hue, sat;
  logic [W-1:0] vmax_pipe_q [W];

  rgbhsv_div_pipe #(
    .QuotBits (W),
    .DivBits  (HW)
  ) u_hue_div (
    .clk_i      (clk_i),
    .en_i       (ld[Stages-1:PRE_STAGES]),
    .dividend_i (hnum4_q),
    .divisor_i  (hdiv4_q),
    .quotient_o (hue)
  );

  rgbhsv_div_pipe #(
    .QuotBits (W),
    .DivBits  (W)
  ) u_sat_div (
    .clk_i      (clk_i),
    .en_i       (ld[Stages-1:PRE_STAGES]),
    .dividend_i (snum4_q),
    .divisor_i  (sdiv4_q),
    .quotient_o (sat)
  );

  always_ff @(posedge clk_i) begin
    if (ld[PRE_STAGES]) vmax_pipe_q[0] <= vmax4_q;
    for (int k = 1; k < W; k++) begin
      if (ld[PRE_STAGES+k]) vmax_pipe_q[k] <= vmax_pipe_q[k-1];
    end
  end

  assign s_axis_tready_o = ld[0];
  assign m_axis_tvalid_o = valid_q[Stages-1];
  assign m_axis_tdata_o  = TW'({vmax_pipe_q[W-1], sat, hue});

  // input stalls only when every stage is full and the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled while pipeline can advance");

  // black pixel has no saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && vmax_pipe_q[W-1] == '0) |-> (sat == '0))
    else $error("nonzero saturation for zero value");

  // hue stays below a full turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (hue != {W{1'b1}}))
    else $error("hue reached full scale");

endmodule

### tb/sv/rgb_to_hsv_converter_test.sv
`timescale 1ns / 1ps

module rgb_to_hsv_converter_test;

  import rgbhsv_pkg::*;

  localparam int unsigned CB = CHANNEL_BITS_DEF;
  localparam int unsigned TDW = tdata_bits(CB);
  localparam int unsigned FULL = (1 << CB) - 1;
  localparam int unsigned LATENCY = CB + 4;

  // last field in the lowest bits
  typedef struct packed {
    logic [CB-1:0] blue;
    logic [CB-1:0] green;
    logic [CB-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [CB-1:0] value;
    logic [CB-1:0] sat;
    logic [CB-1:0] hue;
  } hsv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic src_valid = 1'b0;
  logic [TDW-1:0] src_data = '0;
  logic sink_ready = 1'b0;
  logic sink_hold = 1'b0;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [TDW-1:0] m_axis_tdata_o;

  event hold_start;

  rgb_t pending_pixels[$];
  hsv_t expected_hsv[$];
  hsv_t want_hsv;
  hsv_t got_hsv;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;

  rgb_to_hsv_converter #(
    .CHANNEL_BITS(CB)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(src_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(src_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(sink_ready),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic hsv_t hsv_of_pixel(rgb_t px);
    longint r, g, b, vmax, vmin, spread, num, hue, sat;
    sector_e sect;
    hsv_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    sect = SECT_RED;
    vmax = r;
    if (g > vmax) begin
      sect = SECT_GREEN;
      vmax = g;
    end
    if (b > vmax) begin
      sect = SECT_BLUE;
      vmax = b;
    end
    vmin = r;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    spread = vmax - vmin;
    sat = 0;
    hue = 0;
    if (vmax != 0) sat = (FULL * spread) / vmax;
    if (spread != 0) begin
      case (sect)
        SECT_GREEN: num = 2 * spread + (b - r);
        SECT_BLUE: num = 4 * spread + (r - g);
        default: num = g - b;
      endcase
      // red dominant with green below blue wraps around the turn
      if (num < 0) num = num + 6 * spread;
      hue = (FULL * num) / (6 * spread);
    end
    res.hue = CB'(hue);
    res.sat = CB'(sat);
    res.value = CB'(vmax);
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_valid <= 1'b0;
      src_data <= '0;
    end else begin
      if (src_valid && s_axis_tready_o) begin
        expected_hsv.push_back(hsv_of_pixel(rgb_t'(src_data[3*CB-1:0])));
        pixels_sent++;
      end
      if (!src_valid || s_axis_tready_o) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          src_valid <= 1'b1;
          src_data <= TDW'(pending_pixels.pop_front());
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted in cycles
  initial begin
    @(hold_start);
    sink_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%t mismatch (%s): expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
               $realtime, what, want_hsv.hue, want_hsv.sat, want_hsv.value,
               got_hsv.hue, got_hsv.sat, got_hsv.value);
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
      if (m_axis_tvalid_o && sink_ready) begin
        got_hsv = hsv_t'(m_axis_tdata_o[3*CB-1:0]);
        if (expected_hsv.size() == 0) begin
          want_hsv = '0;
          report_mismatch("unexpected transaction");
        end else begin
          want_hsv = expected_hsv.pop_front();
          results_checked++;
          if (got_hsv.hue !== want_hsv.hue || got_hsv.sat !== want_hsv.sat ||
              got_hsv.value !== want_hsv.value)
            report_mismatch("field");
        end
      end
    end
  end

  task automatic queue_pixel(int unsigned r, int unsigned g, int unsigned b);
    rgb_t px;
    px.red = CB'(r);
    px.green = CB'(g);
    px.blue = CB'(b);
    pending_pixels.push_back(px);
  endtask

  task automatic queue_random_pixels(int unsigned count);
    int unsigned ch[3];
    int unsigned src, dst;
    repeat (count) begin
      foreach (ch[i]) ch[i] = $urandom_range(FULL);
      case ($urandom_range(9))
        0, 1: foreach (ch[i]) ch[i] = $urandom_range(15);
        2: begin
          src = $urandom_range(2);
          dst = $urandom_range(2);
          ch[dst] = ch[src];
        end
        3: foreach (ch[i]) ch[i] = FULL - $urandom_range(15);
        4: begin
          ch[$urandom_range(2)] = $urandom_range(1) ? FULL : 0;
        end
        default: ;
      endcase
      queue_pixel(ch[0], ch[1], ch[2]);
    end
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0 || src_valid || expected_hsv.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, primaries, ties and the wrap of hue below zero
    queue_pixel(0, 0, 0);
    queue_pixel(FULL, FULL, FULL);
    queue_pixel(2048, 2048, 2048);
    queue_pixel(FULL, 0, 0);
    queue_pixel(0, FULL, 0);
    queue_pixel(0, 0, FULL);
    queue_pixel(FULL, FULL, 0);
    queue_pixel(0, FULL, FULL);
    queue_pixel(FULL, 0, FULL);
    queue_pixel(FULL, FULL - 1, 0);
    queue_pixel(FULL, 0, 1);
    queue_pixel(FULL, 1, FULL - 1);
    queue_pixel(1, 0, 0);
    queue_pixel(0, 1, 0);
    queue_pixel(0, 0, 1);
    queue_pixel(1000, 1000, 10);
    queue_pixel(1000, 10, 1000);
    queue_pixel(10, 1000, 1000);
    queue_pixel(FULL, FULL - 1, FULL - 1);
    queue_pixel(1, 2, 3);
    queue_pixel(3, 2, 1);
    queue_pixel(2730, 1365, 4095);

    src_idle_pct = 0;
    sink_stall_pct = 0;
    queue_random_pixels(230);
    drain();

    @(negedge clk_i);
    src_idle_pct = 65;
    sink_stall_pct = 0;
    queue_random_pixels(230);
    drain();

    @(negedge clk_i);
    src_idle_pct = 0;
    sink_stall_pct = 65;
    queue_random_pixels(230);
    drain();

    @(negedge clk_i);
    src_idle_pct = 13;
    sink_stall_pct = 13;
    queue_random_pixels(230);
    drain();

    // long output hold-off while input keeps coming, pipeline must back up
    @(negedge clk_i);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    -> hold_start;
    queue_random_pixels(100);
    drain();

    repeat (2 * LATENCY) @(negedge clk_i);

    $display("pixels sent %0d, results checked %0d, mismatches %0d", pixels_sent,
             results_checked, mismatches);
    $display("covered grey, black, ties, hue wrap, random idle and a long output hold-off");
    if (mismatches == 0 && expected_hsv.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout after %0d pixels and %0d results", pixels_sent, results_checked);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
